@@ sv/swe_pkg.sv @@
// swe_pkg: shared types and constants of the sliding window extreme block
// controller state, command and status structs, register map
// no dependencies
`default_nettype none

package swe_pkg;

    localparam int WLEN_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = WLEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_MINIMUM = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_BACK_RD,
        ST_BACK_CHK,
        ST_PUSH,
        ST_FRONT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic rd_front;
        logic rd_back;
        logic drop_head;
        logic drop_tail;
        logic push;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic expired;
        logic dominated;
        logic due;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

@@ sv/swe_ram.sv @@
// swe_ram: generic single write port, single read port ram
// registered read data, held while read enable is low; no dependencies
`default_nettype none

module swe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/swe_ctrl.sv @@
// swe_ctrl: sequencer for one sample: expire front, drop back, push, report
// depends on swe_pkg
`default_nettype none

module swe_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire swe_pkg::t_status i_status,
    output swe_pkg::t_cmd         o_cmd
);

    import swe_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXP_RD;
            end
            ST_EXP_RD: begin
                n_state = i_status.cnt_zero ? ST_BACK_RD : ST_EXP_CHK;
            end
            ST_EXP_CHK: begin
                n_state = i_status.expired ? ST_EXP_RD : ST_BACK_RD;
            end
            ST_BACK_RD: begin
                n_state = i_status.cnt_zero ? ST_PUSH : ST_BACK_CHK;
            end
            ST_BACK_CHK: begin
                n_state = i_status.dominated ? ST_BACK_RD : ST_PUSH;
            end
            ST_PUSH: begin
                n_state = ST_FRONT;
            end
            ST_FRONT: begin
                if (!i_status.due || !i_status.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (r_state)
            ST_IDLE:     cmd.in_ready  = 1'b1;
            ST_EXP_RD:   cmd.rd_front  = !i_status.cnt_zero;
            ST_EXP_CHK:  cmd.drop_head = i_status.expired;
            ST_BACK_RD:  cmd.rd_back   = !i_status.cnt_zero;
            ST_BACK_CHK: cmd.drop_tail = i_status.dominated;
            ST_PUSH: begin
                cmd.push     = 1'b1;
                cmd.rd_front = 1'b1;
            end
            ST_FRONT:    cmd.load_out  = i_status.due && !i_status.out_busy;
            default:     cmd = '0;
        endcase
    end

    assign o_cmd = cmd;

endmodule

`default_nettype wire

@@ sv/swe_dpath.sv @@
// swe_dpath: candidate ring buffer, counters, config registers, output register
// depends on swe_pkg and swe_ram
`default_nettype none

module swe_dpath #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    input  wire logic                                 i_start_req,
    input  wire logic                                 i_out_ready,
    input  wire logic                                 i_cfg_we,
    input  wire logic        [swe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic        [swe_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire swe_pkg::t_cmd                        i_cmd,
    output swe_pkg::t_status                          o_status,
    output logic                                      o_out_valid,
    output logic signed      [SAMPLE_WIDTH-1:0]       o_extreme
);

    import swe_pkg::*;

    localparam int PW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int IW = $clog2(2 * MAX_WINDOW);
    localparam int LW = (CW > WLEN_W) ? CW : WLEN_W;
    localparam int EW = SAMPLE_WIDTH + IW;

    logic        [WLEN_W-1:0]       r_wlen;
    logic                           r_sel_min;
    logic        [PW-1:0]           r_head;
    logic        [CW-1:0]           r_count;
    logic        [CW-1:0]           r_seen;
    logic        [IW-1:0]           r_idx;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_due;
    logic                           r_use_new;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    logic                           accept;
    logic        [CW-1:0]           eff_len;
    logic        [PW:0]             head_p1;
    logic        [PW-1:0]           head_next;
    logic        [PW:0]             tail_sum;
    logic        [PW:0]             back_sum;
    logic        [PW-1:0]           tail_addr;
    logic        [PW-1:0]           back_addr;
    logic        [PW-1:0]           rd_addr;
    logic                           full;
    logic        [CW-1:0]           seen_next;
    logic        [IW-1:0]           idx_next;
    logic        [EW-1:0]           rdata;
    logic signed [SAMPLE_WIDTH-1:0] rd_val;
    logic        [IW-1:0]           rd_idx;
    logic        [IW:0]             age;
    logic                           expired;
    logic                           dominated;

    assign accept = i_cmd.in_ready && i_in_valid;

    // window length clamped to 1..MAX_WINDOW
    always_comb begin
        if (r_wlen == '0) begin
            eff_len = CW'(1);
        end else if (LW'(r_wlen) > LW'(MAX_WINDOW)) begin
            eff_len = CW'(MAX_WINDOW);
        end else begin
            eff_len = CW'(r_wlen);
        end
    end

    // ring pointers
    assign head_p1   = (PW+1)'(r_head) + (PW+1)'(1);
    assign head_next = (head_p1 == (PW+1)'(MAX_WINDOW)) ? '0 : head_p1[PW-1:0];
    assign tail_sum  = (PW+1)'(r_head) + (PW+1)'(r_count);
    assign back_sum  = tail_sum - (PW+1)'(1);
    assign tail_addr = (tail_sum >= (PW+1)'(MAX_WINDOW))
                       ? PW'(tail_sum - (PW+1)'(MAX_WINDOW)) : tail_sum[PW-1:0];
    assign back_addr = (back_sum >= (PW+1)'(MAX_WINDOW))
                       ? PW'(back_sum - (PW+1)'(MAX_WINDOW)) : back_sum[PW-1:0];
    assign full      = (r_count == CW'(MAX_WINDOW));

    always_comb begin
        if (i_cmd.rd_back) begin
            rd_addr = back_addr;
        end else if (i_cmd.push && full) begin
            rd_addr = head_next;
        end else begin
            rd_addr = r_head;
        end
    end

    swe_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (tail_addr),
        .i_wdata ({r_sample, r_idx}),
        .i_re    (i_cmd.rd_front || i_cmd.rd_back),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign rd_val = rdata[EW-1:IW];
    assign rd_idx = rdata[IW-1:0];

    // age of the candidate, modulo twice the window capacity
    always_comb begin
        if (r_idx >= rd_idx) begin
            age = (IW+1)'(r_idx) - (IW+1)'(rd_idx);
        end else begin
            age = (IW+1)'(r_idx) + (IW+1)'(2 * MAX_WINDOW) - (IW+1)'(rd_idx);
        end
    end

    assign expired   = (age >= (IW+1)'(eff_len));
    assign dominated = r_sel_min ? (rd_val >= r_sample) : (rd_val <= r_sample);
    assign seen_next = (r_seen < eff_len) ? r_seen + CW'(1) : eff_len;
    assign idx_next  = (r_idx == IW'(2 * MAX_WINDOW - 1)) ? '0 : r_idx + IW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen      <= WLEN_W'(1);
            r_sel_min   <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
            r_seen      <= '0;
            r_idx       <= '0;
            r_due       <= 1'b0;
            r_use_new   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WINDOW_LENGTH:  r_wlen    <= i_cfg_data;
                    REG_SELECT_MINIMUM: r_sel_min <= i_cfg_data[0];
                endcase
            end
            if (accept && i_start_req) begin
                r_count <= '0;
                r_seen  <= '0;
                r_idx   <= '0;
            end
            if (i_cmd.drop_head) begin
                r_head  <= head_next;
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.drop_tail) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.push) begin
                if (full) begin
                    r_head <= head_next;
                end else begin
                    r_count <= r_count + CW'(1);
                end
                r_seen    <= seen_next;
                r_idx     <= idx_next;
                r_due     <= (seen_next >= eff_len);
                r_use_new <= (r_count == '0);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.load_out) begin
            r_out <= r_use_new ? r_sample : rd_val;
        end
    end

    always_comb begin
        o_status.cnt_zero  = (r_count == '0);
        o_status.expired   = expired;
        o_status.dominated = dominated;
        o_status.due       = r_due;
        o_status.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_extreme   = r_out;

endmodule

`default_nettype wire

@@ sv/sliding_window_extreme.sv @@
// sliding_window_extreme: streaming window maximum or minimum, top level
// depends on swe_pkg, swe_ctrl, swe_dpath, swe_ram
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_sample, i_start_req
//   out      output     o_out_valid / i_out_ready  o_extreme
//   cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one sample at a time: accept, an expiry scan from the front, a dominance scan from the
// back, push, then report; both scans read the candidates one by one through the single
// read port of the candidate ram, each read followed by a check step that may drop it
// every candidate is dropped at most once, which bounds the scan work over a long run
// synchronous active-low reset; the ram needs no clearing pass
// a stalled output beat holds a sample that is due a result in its final step;
// no next sample is taken meanwhile
`default_nettype none

module sliding_window_extreme #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    input  wire logic                                 i_start_req,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed      [SAMPLE_WIDTH-1:0]       o_extreme,
    input  wire logic                                 i_cfg_we,
    input  wire logic        [swe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic        [swe_pkg::CFG_W-1:0]     i_cfg_data
);

    import swe_pkg::*;

    t_cmd    cmd;
    t_status status;

    swe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    swe_dpath #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_sample    (i_sample),
        .i_start_req (i_start_req),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_extreme   (o_extreme)
    );

    assign o_in_ready = cmd.in_ready;

endmodule

`default_nettype wire

@@ sv/swe_checker.sv @@
// swe_checker: port level checks of sliding_window_extreme, bound to the top level
// depends on sliding_window_extreme
`default_nettype none

module swe_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    i_in_ready,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic [SAMPLE_WIDTH-1:0] i_extreme
);

    // output beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_extreme))
        else $error("output beat dropped or changed while stalled");

    // one sample in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted on consecutive cycles");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // ready for a sample right after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind sliding_window_extreme swe_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_extreme   (o_extreme)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench: self-checking bench for sliding_window_extreme, window max and min over a stream
// queue-fed driver and a monitor with its own candidate-store predictor
// depends on swe_pkg and sliding_window_extreme
`default_nettype none

module testbench;
    import swe_pkg::*;

    localparam int SAMPLE_W       = 16;
    localparam int WIN_MAX        = 64;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 12;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       start;
    } t_sample_beat;

    typedef enum int {
        STYLE_FULL,
        STYLE_NARROW,
        STYLE_FALLING,
        STYLE_RISING,
        STYLE_EXTREMES
    } t_style;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic i_start_req = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_extreme;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    sliding_window_extreme #(
        .MAX_WINDOW  (WIN_MAX),
        .SAMPLE_WIDTH(SAMPLE_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sample   (i_sample),
        .i_start_req(i_start_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_extreme  (o_extreme),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_sample_beat pending_q[$];
    logic signed [SAMPLE_W-1:0] extreme_q[$];

    // predictor state
    logic signed [SAMPLE_W-1:0] cand_val[$];
    logic [WLEN_W-1:0] cand_pos[$];
    int seen_cnt = 0;
    logic [WLEN_W-1:0] next_pos = '0;
    logic [WLEN_W-1:0] wlen_reg = 7'd1;
    logic min_mode = 1'b0;

    logic in_fire = 1'b0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int idle_cycles = 0;
    int ramp_val = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic predict_window(input logic signed [SAMPLE_W-1:0] s, input logic st);
        int len;
        logic [WLEN_W-1:0] age;
        logic dom;
        len = (wlen_reg == 0) ? 1 : ((wlen_reg > WIN_MAX) ? WIN_MAX : int'(wlen_reg));
        if (st) begin
            cand_val.delete();
            cand_pos.delete();
            seen_cnt = 0;
            next_pos = '0;
        end
        while (cand_val.size() > 0) begin
            age = next_pos - cand_pos[0];
            if (int'(age) < len) break;
            cand_val.delete(0);
            cand_pos.delete(0);
        end
        while (cand_val.size() > 0) begin
            dom = min_mode ? (cand_val[$] >= s) : (cand_val[$] <= s);
            if (!dom) break;
            cand_val.delete(cand_val.size() - 1);
            cand_pos.delete(cand_pos.size() - 1);
        end
        if (cand_val.size() >= WIN_MAX) begin
            cand_val.delete(0);
            cand_pos.delete(0);
        end
        cand_val = {cand_val, s};
        cand_pos = {cand_pos, next_pos};
        if (seen_cnt < len) seen_cnt++;
        if (seen_cnt > len) seen_cnt = len;
        next_pos = next_pos + 1'b1;
        if (seen_cnt >= len) extreme_q = {extreme_q, cand_val[0]};
    endtask

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WINDOW_LENGTH:  wlen_reg = i_cfg_data[WLEN_W-1:0];
                    REG_SELECT_MINIMUM: min_mode = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                if (extreme_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result beat: expected none got %0d", o_extreme);
                end else begin
                    if (o_extreme !== extreme_q[0]) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("extreme mismatch: expected %0d got %0d",
                                     extreme_q[0], o_extreme);
                    end
                    extreme_q.delete(0);
                end
            end
            if (i_in_valid && o_in_ready) predict_window(i_sample, i_start_req);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // driver
    always @(negedge i_clk) begin
        i_out_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid  <= 1'b1;
                i_sample    <= pending_q[0].sample;
                i_start_req <= pending_q[0].start;
                pending_q.delete(0);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_sample(input int value, input logic st);
        t_sample_beat b;
        b.sample = SAMPLE_W'(value);
        b.start  = st;
        pending_q = {pending_q, b};
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || i_in_valid || extreme_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int next_sample(input t_style style);
        int v;
        case (style)
            STYLE_NARROW: v = $urandom_range(6) - 3;
            STYLE_FALLING: begin
                ramp_val = ramp_val - $urandom_range(400);
                if (ramp_val < -32768) ramp_val = 32767;
                v = ramp_val;
            end
            STYLE_RISING: begin
                ramp_val = ramp_val + $urandom_range(400);
                if (ramp_val > 32767) ramp_val = -32768;
                v = ramp_val;
            end
            STYLE_EXTREMES: begin
                case ($urandom_range(3))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom);
        endcase
        return v;
    endfunction

    function automatic int pick_wlen();
        int r;
        int w;
        r = $urandom_range(99);
        if (r < 50) w = $urandom_range(8, 1);
        else if (r < 70) w = $urandom_range(63, 9);
        else if (r < 80) w = WIN_MAX;
        else if (r < 90) w = 0;
        else w = $urandom_range(127, 65);
        return w;
    endfunction

    task automatic random_phase(input int n_items, input logic restart);
        t_style style;
        int k;
        style = t_style'($urandom_range(4));
        ramp_val = int'($urandom_range(65535)) - 32768;
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 10) style = t_style'($urandom_range(4));
            if (k == 0) push_sample(next_sample(style), restart);
            else push_sample(next_sample(style), $urandom_range(99) < 3);
        end
    endtask

    initial begin
        int p;
        int r;
        send_idle_pct = 21;
        recv_idle_pct = 53;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // max over three, extremes and ties
        write_reg(REG_WINDOW_LENGTH, 3);
        write_reg(REG_SELECT_MINIMUM, 0);
        end_writes();
        push_sample(5, 1'b1);
        push_sample(32767, 1'b0);
        push_sample(-32768, 1'b0);
        push_sample(-32768, 1'b0);
        push_sample(0, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(-1, 1'b0);
        drain();

        // mode switch mid-sequence
        write_reg(REG_SELECT_MINIMUM, 1);
        end_writes();
        push_sample(2, 1'b0);
        push_sample(2, 1'b0);
        push_sample(-5, 1'b0);
        drain();

        // zero length acts as one
        write_reg(REG_WINDOW_LENGTH, 0);
        end_writes();
        push_sample(100, 1'b1);
        push_sample(-100, 1'b0);
        push_sample(32767, 1'b0);
        drain();

        // oversized length saturates, no full window yet
        write_reg(REG_WINDOW_LENGTH, 127);
        end_writes();
        push_sample(-32768, 1'b0);
        push_sample(1, 1'b0);
        push_sample(-2, 1'b0);
        push_sample(3, 1'b0);
        push_sample(-4, 1'b0);
        drain();

        // shrink mid-sequence, then a restart inside the run
        write_reg(REG_WINDOW_LENGTH, 1);
        end_writes();
        push_sample(9, 1'b0);
        push_sample(-9, 1'b1);
        push_sample(8, 1'b0);
        push_sample(7, 1'b0);
        drain();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p < RANDOM_PHASES / 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 53;
            end else if (p < 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 53;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            r = $urandom_range(99);
            if (r < 80) begin
                write_reg(REG_WINDOW_LENGTH, pick_wlen());
                write_reg(REG_SELECT_MINIMUM, $urandom_range(1));
            end else if (r < 90) begin
                write_reg(REG_WINDOW_LENGTH, pick_wlen());
            end else begin
                write_reg(REG_SELECT_MINIMUM, $urandom_range(1));
            end
            end_writes();
            random_phase($urandom_range(200, 120), $urandom_range(99) < 70);
            drain();
        end

        if (extreme_q.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
